/* hw/rtl/iads_pkg.sv */
// Shared types and constants for the I2C ADC/DAC poll sequencer.
package iads_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Fixed I2C bus constants.
  localparam logic [7:0] READ_LEN         = 8'd2;
  localparam logic [7:0] REG_CONFIG       = 8'h01;
  localparam logic [7:0] REG_CONVERSION   = 8'h00;
  localparam logic [7:0] DAC_READBACK_CMD = 8'h10;
  localparam logic [4:0] RX_EXPECT        = 5'd2;

  // Queued command kinds (code three runs as an ADC cycle).
  localparam logic [1:0] CMD_ADC    = 2'd0;
  localparam logic [1:0] CMD_DAC_WR = 2'd1;
  localparam logic [1:0] CMD_DAC_RD = 2'd2;

  // Result kinds.
  localparam logic [2:0] RES_TX     = 3'd0;
  localparam logic [2:0] RES_BEGIN  = 3'd1;
  localparam logic [2:0] RES_REINIT = 3'd2;
  localparam logic [2:0] RES_MSG    = 3'd3;
  localparam logic [2:0] RES_ACK    = 3'd4;

  // Host message codes.
  localparam logic MSG_READBACK  = 1'b0;
  localparam logic MSG_POWER_OFF = 1'b1;

  // Group of TX words sent at the end of an interrupt.
  typedef enum logic [2:0] {
    GRP_POLL,
    GRP_CONV,
    GRP_DAC_WR,
    GRP_DAC_RD,
    GRP_ADC_WR
  } grp_t;

  // One queued command as stored in the ring memory.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  cmd;
    logic [3:0]  chan;
    logic [15:0] value;
  } ring_entry_t;

  // Configuration register values.
  typedef struct packed {
    logic [11:0] threshold;
    logic [3:0]  module_number;
    logic [6:0]  adc_low_addr;
    logic [6:0]  adc_high_addr;
    logic [6:0]  dac_addr;
    logic [7:0]  setup_high;
    logic [7:0]  setup_low;
  } cfg_t;

  // Everything the emitter needs to play out one interrupt item.
  typedef struct packed {
    logic        reinit;
    logic        msg_valid;
    logic        msg_code;
    logic [11:0] msg_value;
    grp_t        grp;
    logic [2:0]  channel;
    logic [3:0]  cmd;
    logic [3:0]  chan;
    logic [15:0] value;
  } plan_t;

endpackage

/* hw/rtl/iads_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface iads_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  command_kind;
  logic [3:0]  dac_command;
  logic [3:0]  dac_channel;
  logic [15:0] dac_value;
  logic        tx_fifo_empty;
  logic [4:0]  rx_count;
  logic [7:0]  rx_first;
  logic [7:0]  rx_second;

  modport source (
    output valid, opcode, command_kind, dac_command, dac_channel, dac_value,
    output tx_fifo_empty, rx_count, rx_first, rx_second,
    input  ready
  );
  modport sink (
    input  valid, opcode, command_kind, dac_command, dac_channel, dac_value,
    input  tx_fifo_empty, rx_count, rx_first, rx_second,
    output ready
  );
endinterface

interface iads_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        start_flag;
  logic        stop_flag;
  logic [7:0]  data_byte;
  logic        message_code;
  logic [3:0]  message_module;
  logic [11:0] message_value;
  logic        last;

  modport source (
    output valid, kind, start_flag, stop_flag, data_byte, message_code,
    output message_module, message_value, last,
    input  ready
  );
  modport sink (
    input  valid, kind, start_flag, stop_flag, data_byte, message_code,
    input  message_module, message_value, last,
    output ready
  );
endinterface

/* hw/rtl/iic_adc_dac_poll_sequencer.sv */
// Top level of the I2C ADC/DAC poll sequencer.
//
// item_in takes two kinds of item. An enqueue item stores a DAC or ADC
// command in the command ring and produces no result.
// An interrupt item advances the poll state machine and produces four to
// seven result items on result_out, the last one an interrupt acknowledge
// with last set. Results leave one per cycle from an output register
// while result_out is ready; an accepted interrupt passes through the
// plan slot and the emitter's plan register before its first result.
// The plan of one interrupt waits in a slot while the previous one is
// still being emitted, so item_in stays ready while result_out stalls
// until both the slot and the emitter are busy.
// The ring is a single-port-write RAM with a registered read of the head
// entry, prefetched every cycle and bypassed on a write to that entry.
// Reset clears the pointers, the state machine and all valid flags; ring
// contents are left as they are. Configuration is written through the
// APB port; the user must write it only while the block is idle, as the block does not enforce this.
module iic_adc_dac_poll_sequencer import iads_pkg::*; #(
  parameter int RING_DEPTH    = 32,
  parameter int CHANNEL_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  iads_in_if.sink               item_in,
  iads_out_if.source            result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  logic        ring_empty;
  ring_entry_t ring_head;
  logic        push_req;
  ring_entry_t push_entry;
  logic        pop;
  logic        take;
  logic        slot_full;
  plan_t       slot_plan;

  iads_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iads_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .push_req   (push_req),
    .push_entry (push_entry),
    .pop        (pop),
    .empty      (ring_empty),
    .head_entry (ring_head)
  );

  iads_seq #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .threshold  (cfg.threshold),
    .ring_empty (ring_empty),
    .ring_head  (ring_head),
    .push_req   (push_req),
    .push_entry (push_entry),
    .pop        (pop),
    .take       (take),
    .slot_full  (slot_full),
    .slot_plan  (slot_plan)
  );

  iads_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .slot_full  (slot_full),
    .slot_plan  (slot_plan),
    .take       (take),
    .result_out (result_out)
  );

endmodule

/* hw/rtl/iads_cfg.sv */
// APB-style configuration register file.
module iads_cfg import iads_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  localparam logic [2:0] IDX_THRESHOLD  = 3'd0;
  localparam logic [2:0] IDX_MODULE     = 3'd1;
  localparam logic [2:0] IDX_ADC_LOW    = 3'd2;
  localparam logic [2:0] IDX_ADC_HIGH   = 3'd3;
  localparam logic [2:0] IDX_DAC        = 3'd4;
  localparam logic [2:0] IDX_SETUP_HIGH = 3'd5;
  localparam logic [2:0] IDX_SETUP_LOW  = 3'd6;

  logic [2:0] idx;
  logic       wr_en;

  // Registers sit on word boundaries; the byte offset bits are ignored.
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= 12'd0;
      cfg.module_number <= 4'd0;
      cfg.adc_low_addr  <= 7'd72;
      cfg.adc_high_addr <= 7'd73;
      cfg.dac_addr      <= 7'd12;
      cfg.setup_high    <= 8'd0;
      cfg.setup_low     <= 8'd0;
    end else if (wr_en) begin
      case (idx)
        IDX_THRESHOLD:  cfg.threshold     <= pwdata[11:0];
        IDX_MODULE:     cfg.module_number <= pwdata[3:0];
        IDX_ADC_LOW:    cfg.adc_low_addr  <= pwdata[6:0];
        IDX_ADC_HIGH:   cfg.adc_high_addr <= pwdata[6:0];
        IDX_DAC:        cfg.dac_addr      <= pwdata[6:0];
        IDX_SETUP_HIGH: cfg.setup_high    <= pwdata[7:0];
        IDX_SETUP_LOW:  cfg.setup_low     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    case (idx)
      IDX_THRESHOLD:  prdata = {20'd0, cfg.threshold};
      IDX_MODULE:     prdata = {28'd0, cfg.module_number};
      IDX_ADC_LOW:    prdata = {25'd0, cfg.adc_low_addr};
      IDX_ADC_HIGH:   prdata = {25'd0, cfg.adc_high_addr};
      IDX_DAC:        prdata = {25'd0, cfg.dac_addr};
      IDX_SETUP_HIGH: prdata = {24'd0, cfg.setup_high};
      IDX_SETUP_LOW:  prdata = {24'd0, cfg.setup_low};
      default:        prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/iads_ring.sv */
// Command ring: one synchronous memory with head/tail pointers and a prefetched head entry.
module iads_ring import iads_pkg::*; #(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_req,
  input  ring_entry_t push_entry,
  input  logic        pop,
  output logic        empty,
  output ring_entry_t head_entry
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  ring_entry_t   mem [RING_DEPTH];
  ring_entry_t   rd_q;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] head_next;
  logic          full;
  logic          push;

  // Pointer arithmetic with wrap at the ring depth.
  assign head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign full      = (tail_inc == head);
  assign empty     = (head == tail);
  assign push      = push_req & ~full;
  assign head_next = pop ? head_inc : head;
  assign head_entry = rd_q;

  // Pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        tail <= tail_inc;
      end
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_entry;
    end
  end

  // Read port keeps the entry at the next head ready; a push into that
  // same slot is forwarded so an item right after an enqueue sees it.
  always_ff @(posedge clk) begin
    if (push && (tail == head_next)) begin
      rd_q <= push_entry;
    end else begin
      rd_q <= mem[head_next];
    end
  end

endmodule

/* hw/rtl/iads_seq.sv */
// Poll sequencer state machine: decides the results of each interrupt item.
module iads_seq import iads_pkg::*; #(
  parameter int CHANNEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  iads_in_if.sink     item_in,
  input  logic [11:0] threshold,
  input  logic        ring_empty,
  input  ring_entry_t ring_head,
  output logic        push_req,
  output ring_entry_t push_entry,
  output logic        pop,
  input  logic        take,
  output logic        slot_full,
  output plan_t       slot_plan
);

  typedef enum logic [2:0] {
    PH_WRITE,
    PH_WAIT_TOP,
    PH_WAIT_BOT,
    PH_RD_TOP,
    PH_RD_BOT
  } phase_t;

  localparam logic [2:0] CH_LAST = 3'(CHANNEL_COUNT - 1);

  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  channel;
  logic [2:0]  channel_next;
  logic [1:0]  cur_kind;
  logic [1:0]  cur_kind_next;
  plan_t       plan;
  logic        accept;
  logic        is_irq;
  logic        rx_ok;
  logic        read_en;
  logic        write_en;
  logic [11:0] reading;
  ring_entry_t entry;

  assign item_in.ready = ~slot_full | take;
  assign accept   = item_in.valid & item_in.ready;
  assign is_irq   = item_in.opcode;
  assign rx_ok    = (item_in.rx_count == RX_EXPECT);
  assign reading  = {item_in.rx_first, item_in.rx_second[7:4]};

  // Enqueue items go straight to the ring.
  assign push_req   = accept & ~is_irq;
  assign push_entry = '{kind:  item_in.command_kind,
                        cmd:   item_in.dac_command,
                        chan:  item_in.dac_channel,
                        value: item_in.dac_value};
  assign pop = accept & is_irq & write_en & ~ring_empty;

  // Phase step for one interrupt: an optional read, then either a poll,
  // a conversion read or the write of the next command.
  always_comb begin
    plan          = '0;
    plan.grp      = GRP_ADC_WR;
    phase_next    = phase;
    channel_next  = channel;
    cur_kind_next = cur_kind;
    read_en       = 1'b0;
    write_en      = 1'b0;
    entry         = '0;

    if (!item_in.tx_fifo_empty) begin
      plan.reinit = 1'b1;
      write_en    = 1'b1;
    end else begin
      case (phase)
        PH_WAIT_TOP: begin
          plan.grp   = GRP_POLL;
          phase_next = PH_WAIT_BOT;
        end
        PH_WAIT_BOT: begin
          if (!rx_ok) begin
            plan.reinit = 1'b1;
            write_en    = 1'b1;
          end else if (item_in.rx_first[7]) begin
            plan.grp   = GRP_CONV;
            phase_next = PH_RD_BOT;
          end else begin
            plan.grp   = GRP_POLL;
            phase_next = PH_WAIT_BOT;
          end
        end
        PH_RD_TOP: begin
          plan.grp   = GRP_CONV;
          phase_next = PH_RD_BOT;
        end
        PH_RD_BOT: begin
          if (!rx_ok) begin
            plan.reinit = 1'b1;
          end else begin
            read_en = 1'b1;
          end
          write_en = 1'b1;
        end
        default: begin
          write_en = 1'b1;
        end
      endcase
    end

    // Finished read: DAC readback message, or ADC reading check.
    if (read_en) begin
      if (cur_kind == CMD_DAC_RD) begin
        plan.msg_valid = 1'b1;
        plan.msg_code  = MSG_READBACK;
        plan.msg_value = reading;
      end else begin
        if (reading < threshold) begin
          plan.msg_valid = 1'b1;
          plan.msg_code  = MSG_POWER_OFF;
        end
        channel_next = (channel == CH_LAST) ? 3'd0 : channel + 3'd1;
      end
    end

    // Write phase: take the next queued command, else an ADC cycle.
    if (write_en) begin
      if (!ring_empty) begin
        entry = ring_head;
      end
      cur_kind_next = entry.kind;
      case (entry.kind)
        CMD_DAC_WR: begin
          plan.grp   = GRP_DAC_WR;
          phase_next = PH_WRITE;
        end
        CMD_DAC_RD: begin
          plan.grp   = GRP_DAC_RD;
          phase_next = PH_RD_BOT;
        end
        default: begin
          plan.grp   = GRP_ADC_WR;
          phase_next = PH_WAIT_TOP;
        end
      endcase
    end

    plan.channel = channel_next;
    plan.cmd     = entry.cmd;
    plan.chan    = entry.chan;
    plan.value   = entry.value;
  end

  // State and the plan slot handed to the emitter.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WRITE;
      channel   <= 3'd0;
      cur_kind  <= CMD_ADC;
      slot_full <= 1'b0;
    end else begin
      if (take) begin
        slot_full <= 1'b0;
      end
      if (accept && is_irq) begin
        slot_full <= 1'b1;
        slot_plan <= plan;
        phase     <= phase_next;
        channel   <= channel_next;
        cur_kind  <= cur_kind_next;
      end
    end
  end

endmodule

/* hw/rtl/iads_emit.sv */
// Result emitter: plays out one plan as result items through an output register.
module iads_emit import iads_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      slot_full,
  input  plan_t     slot_plan,
  output logic      take,
  iads_out_if.source result_out
);

  typedef struct packed {
    logic [2:0]  kind;
    logic        start_flag;
    logic        stop_flag;
    logic [7:0]  data_byte;
    logic        message_code;
    logic [3:0]  message_module;
    logic [11:0] message_value;
    logic        last;
  } result_t;

  plan_t      plan_q;
  logic       busy;
  logic [2:0] pos;
  logic       out_valid;
  result_t    result_q;
  result_t    res;
  logic       pre;
  logic [2:0] step;
  logic [2:0] ntx;
  logic [1:0] txi;
  logic [6:0] adc_addr;
  logic       advance;

  assign take     = slot_full & ~busy;
  assign advance  = busy & (~out_valid | result_out.ready);
  assign pre      = plan_q.reinit | plan_q.msg_valid;
  assign step     = pos - {2'b00, pre};
  assign ntx      = (plan_q.grp == GRP_POLL) ? 3'd2 : 3'd4;
  assign txi      = 2'(step - 3'd1);
  assign adc_addr = plan_q.channel[2] ? cfg.adc_high_addr : cfg.adc_low_addr;

  // Result at the current position: [reinit or message], begin, TX words, ack.
  always_comb begin
    res = '0;
    if (pre && (pos == 3'd0)) begin
      if (plan_q.reinit) begin
        res.kind = RES_REINIT;
      end else begin
        res.kind           = RES_MSG;
        res.message_code   = plan_q.msg_code;
        res.message_module = cfg.module_number;
        res.message_value  = plan_q.msg_value;
      end
    end else if (step == 3'd0) begin
      res.kind = RES_BEGIN;
    end else if (step > ntx) begin
      res.kind = RES_ACK;
      res.last = 1'b1;
    end else begin
      res.kind = RES_TX;
      case (plan_q.grp)
        GRP_POLL: begin
          case (txi)
            2'd0: begin
              res.start_flag = 1'b1;
              res.data_byte  = {adc_addr, 1'b1};
            end
            default: begin
              res.stop_flag = 1'b1;
              res.data_byte = READ_LEN;
            end
          endcase
        end
        GRP_CONV: begin
          case (txi)
            2'd0: begin
              res.start_flag = 1'b1;
              res.data_byte  = {adc_addr, 1'b0};
            end
            2'd1: res.data_byte = REG_CONVERSION;
            2'd2: begin
              res.start_flag = 1'b1;
              res.data_byte  = {adc_addr, 1'b1};
            end
            default: begin
              res.stop_flag = 1'b1;
              res.data_byte = READ_LEN;
            end
          endcase
        end
        GRP_DAC_WR: begin
          case (txi)
            2'd0: begin
              res.start_flag = 1'b1;
              res.data_byte  = {cfg.dac_addr, 1'b0};
            end
            2'd1: res.data_byte = {plan_q.cmd, plan_q.chan};
            2'd2: res.data_byte = plan_q.value[15:8];
            default: begin
              res.stop_flag = 1'b1;
              res.data_byte = plan_q.value[7:0];
            end
          endcase
        end
        GRP_DAC_RD: begin
          case (txi)
            2'd0: begin
              res.start_flag = 1'b1;
              res.data_byte  = {cfg.dac_addr, 1'b0};
            end
            2'd1: res.data_byte = DAC_READBACK_CMD | {4'd0, plan_q.chan};
            2'd2: begin
              res.start_flag = 1'b1;
              res.data_byte  = {cfg.dac_addr, 1'b1};
            end
            default: begin
              res.stop_flag = 1'b1;
              res.data_byte = READ_LEN;
            end
          endcase
        end
        default: begin
          case (txi)
            2'd0: begin
              res.start_flag = 1'b1;
              res.data_byte  = {adc_addr, 1'b0};
            end
            2'd1: res.data_byte = REG_CONFIG;
            2'd2: res.data_byte = cfg.setup_high | {2'b00, plan_q.channel[1:0], 4'd0};
            default: begin
              res.stop_flag = 1'b1;
              res.data_byte = cfg.setup_low;
            end
          endcase
        end
      endcase
    end
  end

  // Plan register, position counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy   <= 1'b1;
        plan_q <= slot_plan;
        pos    <= 3'd0;
      end
      if (advance) begin
        result_q  <= res;
        out_valid <= 1'b1;
        pos       <= pos + 3'd1;
        if (res.last) begin
          busy <= 1'b0;
        end
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.kind           = result_q.kind;
  assign result_out.start_flag     = result_q.start_flag;
  assign result_out.stop_flag      = result_q.stop_flag;
  assign result_out.data_byte      = result_q.data_byte;
  assign result_out.message_code   = result_q.message_code;
  assign result_out.message_module = result_q.message_module;
  assign result_out.message_value  = result_q.message_value;
  assign result_out.last           = result_q.last;

endmodule

/* hw/rtl/iads_check.sv */
// Port-level checker for the poll sequencer and its bind to the top level.
module iads_check import iads_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic        start_flag,
  input logic        stop_flag,
  input logic [7:0]  data_byte,
  input logic [3:0]  message_module,
  input logic [11:0] message_value,
  input logic        last
);

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(data_byte) && $stable(last))
    else $error("result payload changed while stalled");

  // Only the interrupt acknowledge closes an item.
  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == RES_ACK)))
    else $error("last flag does not match acknowledge");

  // Fields that do not belong to a result kind other than TX stay zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != RES_TX) |->
      !start_flag && !stop_flag && (data_byte == 8'd0) &&
      ((kind == RES_MSG) || ((message_module == 4'd0) && (message_value == 12'd0))))
    else $error("unused result field not zero");

endmodule

bind iic_adc_dac_poll_sequencer iads_check u_iads_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .kind           (result_out.kind),
  .start_flag     (result_out.start_flag),
  .stop_flag      (result_out.stop_flag),
  .data_byte      (result_out.data_byte),
  .message_module (result_out.message_module),
  .message_value  (result_out.message_value),
  .last           (result_out.last)
);
